@@ rtl/core/tcfs_pkg.sv @@
// shared types and constants for the text to can frame segmenter
package tcfs_pkg;

    localparam int unsigned CHARS_PER_FRAME_DEF = 6;
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned PAYLOAD_W    = 48;
    localparam int unsigned FILL_W       = 3;
    localparam int unsigned ID_W         = 12;
    localparam int unsigned LEN_W        = 4;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam int unsigned MAX_CHARS    = PAYLOAD_W / CHAR_W;

    localparam logic [ID_W-1:0]   ID_BASE          = 12'h100;
    localparam logic [7:0]        FINAL_MARK       = 8'd128;
    localparam logic [LEN_W-1:0]  HEADER_BYTES     = 4'd2;
    localparam logic [7:0]        STRING_LIMIT_RST = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_NODE_ADDR    = 3'd1,
        REG_PRINT_CLASS  = 3'd2,
        REG_STRING_LIMIT = 3'd3
    } t_cfg_reg;

    typedef struct packed {
        logic       enable;
        logic [7:0] node_addr;
        logic [7:0] print_class;
        logic [7:0] string_limit;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              char_valid;
        logic              last;
    } t_char_item;

    typedef struct packed {
        logic [ID_W-1:0]      message_id;
        logic [LEN_W-1:0]     frame_length;
        logic [7:0]           header_byte;
        logic [7:0]           sequence_byte;
        logic [PAYLOAD_W-1:0] payload;
        logic                 final_frame;
    } t_frame;

endpackage

@@ rtl/core/tcfs_ifs.sv @@
// valid/ready channel interfaces for characters, frames and configuration writes
interface tcfs_char_if import tcfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              char_valid;
    logic              last;

    modport source (output valid, output character, output char_valid, output last,
                    input ready);
    modport sink   (input valid, input character, input char_valid, input last,
                    output ready);
endinterface

interface tcfs_frame_if import tcfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      message_id;
    logic [LEN_W-1:0]     frame_length;
    logic [7:0]           header_byte;
    logic [7:0]           sequence_byte;
    logic [PAYLOAD_W-1:0] payload;
    logic                 final_frame;

    modport source (output valid, output message_id, output frame_length,
                    output header_byte, output sequence_byte, output payload,
                    output final_frame, input ready);
    modport sink   (input valid, input message_id, input frame_length,
                    input header_byte, input sequence_byte, input payload,
                    input final_frame, output ready);
endinterface

interface tcfs_cfg_if import tcfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/tcfs_cfg_regs.sv @@
// configuration register file
module tcfs_cfg_regs import tcfs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output logic                  o_wr_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (t_cfg_reg'(i_wr_index))
                REG_ENABLE:       n_cfg.enable       = i_wr_data[0];
                REG_NODE_ADDR:    n_cfg.node_addr    = i_wr_data[7:0];
                REG_PRINT_CLASS:  n_cfg.print_class  = i_wr_data[7:0];
                REG_STRING_LIMIT: n_cfg.string_limit = i_wr_data[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable       <= 1'b0;
            r_cfg.node_addr    <= '0;
            r_cfg.print_class  <= '0;
            r_cfg.string_limit <= STRING_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/core/tcfs_in_stage.sv @@
// input register stage for character transactions
module tcfs_in_stage import tcfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_char_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    output t_char_item o_item,
    input  logic       i_take
);

    logic       r_valid;
    t_char_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/core/tcfs_packer.sv @@
// frame packing state, counters and frame output register
module tcfs_packer import tcfs_pkg::*; #(
    parameter int unsigned CHARS_PER_FRAME = CHARS_PER_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  t_char_item i_item,
    output logic       o_take,
    output logic       o_valid,
    output t_frame     o_frame,
    input  logic       i_ready
);

    logic [PAYLOAD_W-1:0] r_pending;
    logic [FILL_W-1:0]    r_fill;
    logic [7:0]           r_block;
    logic [7:0]           r_string;
    logic                 r_out_valid;
    t_frame               r_frame;

    logic [PAYLOAD_W-1:0] n_pending;
    logic [FILL_W-1:0]    n_fill;
    logic [7:0]           n_block;
    logic [7:0]           n_string;
    logic [PAYLOAD_W-1:0] merged;
    logic [FILL_W-1:0]    merged_fill;
    logic [7:0]           string_inc;
    logic                 full;
    logic                 emit;
    logic                 slot_free;
    logic                 fire;
    t_frame               frame;

    // byte lane k takes the character when it is the next free slot
    always_comb begin
        for (int k = 0; k < MAX_CHARS; k++) begin
            merged[k*CHAR_W +: CHAR_W] =
                (i_item.char_valid && r_fill == FILL_W'(k)) ? i_item.character
                                                            : r_pending[k*CHAR_W +: CHAR_W];
        end
    end

    assign merged_fill = r_fill + FILL_W'(i_item.char_valid);
    assign full        = i_item.char_valid && !i_item.last
                         && merged_fill == FILL_W'(CHARS_PER_FRAME);
    assign emit        = i_cfg.enable && (i_item.last || full);
    assign slot_free   = !r_out_valid || i_ready;
    // items that make no frame drain even while the output is stalled
    assign fire        = i_valid && (slot_free || !emit);
    assign o_take      = fire;
    assign string_inc  = r_string + 8'd1;

    always_comb begin
        frame.message_id    = ID_BASE | {i_cfg.node_addr, 4'b0000}
                              | {4'b0000, i_cfg.print_class};
        frame.frame_length  = i_item.last ? LEN_W'(merged_fill) + HEADER_BYTES
                                          : LEN_W'(CHARS_PER_FRAME + 2);
        frame.header_byte   = i_item.last ? i_cfg.print_class + FINAL_MARK
                                          : i_cfg.print_class;
        frame.sequence_byte = r_block + {r_string[3:0], 4'b0000};
        frame.payload       = merged;
        frame.final_frame   = i_item.last;
    end

    always_comb begin
        n_pending = r_pending;
        n_fill    = r_fill;
        n_block   = r_block;
        n_string  = r_string;
        if (fire && i_cfg.enable) begin
            if (emit) begin
                n_pending = '0;
                n_fill    = '0;
                if (i_item.last) begin
                    n_block  = '0;
                    n_string = (string_inc == i_cfg.string_limit) ? 8'd0 : string_inc;
                end else begin
                    n_block = r_block + 8'd1;
                end
            end else begin
                n_pending = merged;
                n_fill    = merged_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_fill      <= '0;
            r_block     <= '0;
            r_string    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_fill    <= n_fill;
            r_block   <= n_block;
            r_string  <= n_string;
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_frame <= frame;
        end
    end

    assign o_valid = r_out_valid;
    assign o_frame = r_frame;

endmodule

@@ rtl/core/text_to_can_frame_segmenter.sv @@
// top level: packs text characters into can print frames
//
//   channel   dir  handshake          payload
//   i_char    in   valid/ready        character, char_valid, last
//   o_frame   out  valid/ready        message_id, frame_length, header_byte,
//                                     sequence_byte, payload, final_frame
//   i_cfg     in   valid/ready        index, data (ready always high)
//
// one character per cycle unless a stalled frame output blocks; an item passes through the input
// register and then its frame is registered in the output register
// synchronous active low reset clears the counters, pending characters and valid flags
// a stalled frame output holds the input register only for items that make a frame
// configuration writes take effect on the next cycle
module text_to_can_frame_segmenter import tcfs_pkg::*; #(
    parameter int unsigned CHARS_PER_FRAME = CHARS_PER_FRAME_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcfs_char_if.sink    i_char,
    tcfs_frame_if.source o_frame,
    tcfs_cfg_if.sink     i_cfg
);

    t_cfg       cfg;
    t_char_item in_item;
    t_char_item st_item;
    logic       st_valid;
    logic       st_take;
    logic       in_ready;
    logic       cfg_ready;
    logic       frame_valid;
    t_frame     frame;

    assign in_item.character  = i_char.character;
    assign in_item.char_valid = i_char.char_valid;
    assign in_item.last       = i_char.last;
    assign i_char.ready       = in_ready;
    assign i_cfg.ready        = cfg_ready;

    tcfs_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (cfg_ready),
        .o_cfg      (cfg)
    );

    tcfs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .i_item  (in_item),
        .o_ready (in_ready),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (st_take)
    );

    tcfs_packer #(
        .CHARS_PER_FRAME (CHARS_PER_FRAME)
    ) u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (st_valid),
        .i_item  (st_item),
        .o_take  (st_take),
        .o_valid (frame_valid),
        .o_frame (frame),
        .i_ready (o_frame.ready)
    );

    assign o_frame.valid         = frame_valid;
    assign o_frame.message_id    = frame.message_id;
    assign o_frame.frame_length  = frame.frame_length;
    assign o_frame.header_byte   = frame.header_byte;
    assign o_frame.sequence_byte = frame.sequence_byte;
    assign o_frame.payload       = frame.payload;
    assign o_frame.final_frame   = frame.final_frame;

endmodule
